>>> hdl/dpb_pkg.sv
`timescale 1ns / 1ps

package dpb_pkg;

  // Register map, one 32-bit word each
  typedef enum logic [2:0] {
    REG_INV_FACTOR = 3'd0,
    REG_CX_Q4      = 3'd1,
    REG_CY_Q4      = 3'd2,
    REG_INV_FX     = 3'd3,
    REG_INV_FY     = 3'd4
  } reg_idx_t;

  localparam int ADDR_BITS = 5;

  // Reset values of the registers
  localparam logic [31:0] INV_FACTOR_RST = 32'd4294967;
  localparam logic [14:0] CX_Q4_RST      = 15'd5120;
  localparam logic [14:0] CY_Q4_RST      = 15'd3840;
  localparam logic [23:0] INV_FX_RST     = 24'd28679;
  localparam logic [23:0] INV_FY_RST     = 24'd28679;

  // Depth codes that carry no measurement
  localparam logic [15:0] DEPTH_NONE_LO = 16'd0;
  localparam logic [15:0] DEPTH_NONE_HI = 16'd65535;

  // Fixed-point shifts
  localparam int SHIFT_Z  = 16;
  localparam int SHIFT_XY = 28;

  // Clamp a projected magnitude to signed 32 bits and apply its sign
  function automatic logic [31:0] sat_axis(input logic neg, input logic ovf,
                                           input logic [31:0] q_lo);
    logic [31:0] res;
    if (!neg) begin
      res = (ovf || q_lo[31]) ? 32'h7FFF_FFFF : q_lo;
    end else begin
      res = (ovf || q_lo[31]) ? 32'h8000_0000 : (32'd0 - q_lo);
    end
    return res;
  endfunction

endpackage

>>> hdl/depth_pixel_backprojection.sv
`timescale 1ns / 1ps

// Channel   Dir  Transaction                       Payload
// s_axis    in   one depth pixel per transaction   s_tdata: depth, row, col
// m_axis    out  one 3D point per valid pixel      m_tdata: point_x, point_y, point_z
// apb       in   register write / read             inv_factor, cx_q4, cy_q4, inv_fx, inv_fy
//
// Throughput is one pixel per clock while the output is not stalled; a point leaves
// after its pixel passes the four pipeline stages and the output register.
// Stage work: depth multiply, offset times z, reciprocal multiply, round, clamp.
// Pixels with depth 0 or 65535 are dropped at the input stage.
// rst is synchronous and clears valid bits and the registers to their reset values.
// Each stage holds while the stage after it is full and stalled; nothing is lost.

module depth_pixel_backprojection #(
  parameter int COORD_BITS = 11
) (
  input  logic                                   clk,
  input  logic                                   rst,
  // depth [15:0], row [16 +: COORD_BITS], col [16+COORD_BITS +: COORD_BITS]
  input  logic [((16+2*COORD_BITS+7)/8)*8-1:0]   s_tdata,
  input  logic                                   s_tvalid,
  output logic                                   s_tready,
  // point_x [31:0], point_y [63:32], point_z [95:64]
  output logic [95:0]                            m_tdata,
  output logic                                   m_tvalid,
  input  logic                                   m_tready,
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [dpb_pkg::ADDR_BITS-1:0]          paddr,
  input  logic [31:0]                            pwdata,
  output logic [31:0]                            prdata,
  output logic                                   pready
);

  // Offset magnitude width, product widths
  localparam int MW  = (COORD_BITS + 4 > 15) ? COORD_BITS + 4 : 15;
  localparam int AW  = MW + 32;
  localparam int HIW = MW + 24;
  localparam int LOW = 56;
  localparam int QW  = HIW + 5;

  // Configuration registers
  logic [31:0] inv_factor;
  logic [14:0] cx_q4;
  logic [14:0] cy_q4;
  logic [23:0] inv_fx;
  logic [23:0] inv_fy;
  dpb_pkg::reg_idx_t reg_idx;
  logic cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = dpb_pkg::reg_idx_t'(paddr[4:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  // Write registers on the access cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      inv_factor <= dpb_pkg::INV_FACTOR_RST;
      cx_q4      <= dpb_pkg::CX_Q4_RST;
      cy_q4      <= dpb_pkg::CY_Q4_RST;
      inv_fx     <= dpb_pkg::INV_FX_RST;
      inv_fy     <= dpb_pkg::INV_FY_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        dpb_pkg::REG_INV_FACTOR: inv_factor <= pwdata;
        dpb_pkg::REG_CX_Q4:      cx_q4      <= pwdata[14:0];
        dpb_pkg::REG_CY_Q4:      cy_q4      <= pwdata[14:0];
        dpb_pkg::REG_INV_FX:     inv_fx     <= pwdata[23:0];
        dpb_pkg::REG_INV_FY:     inv_fy     <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  // Read back registers
  always_comb begin
    unique case (reg_idx)
      dpb_pkg::REG_INV_FACTOR: prdata = inv_factor;
      dpb_pkg::REG_CX_Q4:      prdata = {17'd0, cx_q4};
      dpb_pkg::REG_CY_Q4:      prdata = {17'd0, cy_q4};
      dpb_pkg::REG_INV_FX:     prdata = {8'd0, inv_fx};
      dpb_pkg::REG_INV_FY:     prdata = {8'd0, inv_fy};
      default:                 prdata = 32'd0;
    endcase
  end

  // Input fields
  logic [15:0]           depth;
  logic [COORD_BITS-1:0] row;
  logic [COORD_BITS-1:0] col;
  logic                  depth_ok;

  assign depth    = s_tdata[15:0];
  assign row      = s_tdata[16 +: COORD_BITS];
  assign col      = s_tdata[16+COORD_BITS +: COORD_BITS];
  assign depth_ok = (depth != dpb_pkg::DEPTH_NONE_LO) && (depth != dpb_pkg::DEPTH_NONE_HI);

  // Stage valid bits and the load chain from the output back
  logic v1, v2, v3, v4;
  logic load1, load2, load3, load4, load_out;

  assign load_out = !m_tvalid || m_tready;
  assign load4    = !v4 || load_out;
  assign load3    = !v3 || load4;
  assign load2    = !v2 || load3;
  assign load1    = !v1 || load2;
  assign s_tready = load1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1       <= 1'b0;
      v2       <= 1'b0;
      v3       <= 1'b0;
      v4       <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (load1)    v1       <= s_tvalid && depth_ok;
      if (load2)    v2       <= v1;
      if (load3)    v3       <= v2;
      if (load4)    v4       <= v3;
      if (load_out) m_tvalid <= v4;
    end
  end

  // Stage 1: depth times reciprocal scale, pixel offsets from the principal point
  logic [47:0] z_prod;
  logic [MW:0] pix_x, cen_x, pix_y, cen_y, dif_x, dif_y;
  logic        neg_x0, neg_y0;

  always_comb begin
    z_prod = 48'(depth) * 48'(inv_factor);
    pix_x  = (MW+1)'({col, 4'b0000});
    cen_x  = (MW+1)'(cx_q4);
    pix_y  = (MW+1)'({row, 4'b0000});
    cen_y  = (MW+1)'(cy_q4);
    neg_x0 = cen_x > pix_x;
    neg_y0 = cen_y > pix_y;
    dif_x  = neg_x0 ? (cen_x - pix_x) : (pix_x - cen_x);
    dif_y  = neg_y0 ? (cen_y - pix_y) : (pix_y - cen_y);
  end

  logic [31:0]   z1;
  logic [MW-1:0] mag_x1, mag_y1;
  logic          neg_x1, neg_y1;

  always_ff @(posedge clk) begin
    if (load1) begin
      z1     <= z_prod[dpb_pkg::SHIFT_Z +: 32];
      mag_x1 <= dif_x[MW-1:0];
      mag_y1 <= dif_y[MW-1:0];
      neg_x1 <= neg_x0;
      neg_y1 <= neg_y0;
    end
  end

  // Stage 2: offset magnitude times z
  logic [AW-1:0] a_x2, a_y2;
  logic [31:0]   z2;
  logic          neg_x2, neg_y2;

  always_ff @(posedge clk) begin
    if (load2) begin
      a_x2   <= AW'(mag_x1) * AW'(z1);
      a_y2   <= AW'(mag_y1) * AW'(z1);
      z2     <= z1;
      neg_x2 <= neg_x1;
      neg_y2 <= neg_y1;
    end
  end

  // Stage 3: split product times focal reciprocal, high and low halves
  logic [HIW-1:0] hi_x3, hi_y3;
  logic [LOW-1:0] lo_x3, lo_y3;
  logic [31:0]    z3;
  logic           neg_x3, neg_y3;

  always_ff @(posedge clk) begin
    if (load3) begin
      hi_x3  <= HIW'(a_x2[AW-1:32]) * HIW'(inv_fx);
      hi_y3  <= HIW'(a_y2[AW-1:32]) * HIW'(inv_fy);
      lo_x3  <= LOW'(a_x2[31:0]) * LOW'(inv_fx);
      lo_y3  <= LOW'(a_y2[31:0]) * LOW'(inv_fy);
      z3     <= z2;
      neg_x3 <= neg_x2;
      neg_y3 <= neg_y2;
    end
  end

  // Stage 4: recombine, round toward minus infinity on negative offsets
  logic        rem_x, rem_y;
  logic [QW-1:0] q_x4, q_y4;
  logic [31:0]   z4;
  logic          neg_x4, neg_y4;

  assign rem_x = |lo_x3[dpb_pkg::SHIFT_XY-1:0];
  assign rem_y = |lo_y3[dpb_pkg::SHIFT_XY-1:0];

  always_ff @(posedge clk) begin
    if (load4) begin
      q_x4   <= QW'({hi_x3, 4'b0000}) + QW'(lo_x3[LOW-1:dpb_pkg::SHIFT_XY])
                + QW'(neg_x3 && rem_x);
      q_y4   <= QW'({hi_y3, 4'b0000}) + QW'(lo_y3[LOW-1:dpb_pkg::SHIFT_XY])
                + QW'(neg_y3 && rem_y);
      z4     <= z3;
      neg_x4 <= neg_x3;
      neg_y4 <= neg_y3;
    end
  end

  // Output register: clamp and sign
  always_ff @(posedge clk) begin
    if (load_out) begin
      m_tdata[31:0]  <= dpb_pkg::sat_axis(neg_x4, |q_x4[QW-1:32], q_x4[31:0]);
      m_tdata[63:32] <= dpb_pkg::sat_axis(neg_y4, |q_y4[QW-1:32], q_y4[31:0]);
      m_tdata[95:64] <= z4;
    end
  end

`ifndef SYNTHESIS
  // A point at zero depth lies at the origin
  a_zero_depth_origin: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tdata[95:64] == 32'd0)) |-> (m_tdata[63:0] == 64'd0))
    else $error("point with zero depth is off the origin");

  // An empty output never backs up the input
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty output");

  // A measured pixel enters the first stage
  a_enter_stage: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && depth_ok) |=> v1)
    else $error("accepted pixel lost at the first stage");
`endif

endmodule

>>> verif/point_checker.sv
`timescale 1ns / 1ps

// Watches the pixel, point and register channels of depth_pixel_backprojection,
// predicts each 3D point from its own copy of the registers, and compares.
module point_checker #(
  parameter int COORD_BITS = 11,
  parameter int SDATA_W    = ((16 + 2 * COORD_BITS + 7) / 8) * 8
) (
  input  logic                          clk,
  input  logic                          rst,
  // depth [15:0], row [16 +: COORD_BITS], col [16+COORD_BITS +: COORD_BITS]
  input  logic [SDATA_W-1:0]            s_tdata,
  input  logic                          s_tvalid,
  input  logic                          s_tready,
  // point_x [31:0], point_y [63:32], point_z [95:64]
  input  logic [95:0]                   m_tdata,
  input  logic                          m_tvalid,
  input  logic                          m_tready,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [dpb_pkg::ADDR_BITS-1:0] paddr,
  input  logic [31:0]                   pwdata,
  input  logic                          pready,
  output int                            errors,
  output int                            pending
);

  typedef struct packed {
    logic [31:0] z;
    logic [31:0] y;
    logic [31:0] x;
  } point_t;

  // Shadow copy of the camera registers
  logic [31:0] inv_factor;
  logic [14:0] cx_q4;
  logic [14:0] cy_q4;
  logic [23:0] inv_fx;
  logic [23:0] inv_fy;

  point_t expected_points[$];

  initial begin
    errors  = 0;
    pending = 0;
  end

  // Exact floor((coord*16 - centre) * z * recip / 2^28), clamped to signed 32 bits
  function automatic logic [31:0] project_axis(input logic [COORD_BITS-1:0] coord,
                                               input logic [14:0] centre,
                                               input logic [31:0] z,
                                               input logic [23:0] recip);
    logic [19:0]        pix;
    logic signed [19:0] offs;
    logic signed [79:0] prod;
    logic signed [79:0] quo;
    pix  = 20'(coord) << 4;
    offs = $signed(pix) - $signed(20'(centre));
    prod = offs * $signed({1'b0, z}) * $signed({1'b0, recip});
    quo  = prod >>> dpb_pkg::SHIFT_XY;
    if (quo > 80'sd2147483647)
      return 32'h7FFF_FFFF;
    if (quo < -80'sd2147483648)
      return 32'h8000_0000;
    return quo[31:0];
  endfunction

  function automatic point_t backproject(input logic [15:0] depth,
                                         input logic [COORD_BITS-1:0] row,
                                         input logic [COORD_BITS-1:0] col);
    point_t pt;
    logic [47:0] scaled;
    scaled = 48'(depth) * 48'(inv_factor);
    pt.z   = 32'(scaled >> dpb_pkg::SHIFT_Z);
    pt.x   = project_axis(col, cx_q4, pt.z, inv_fx);
    pt.y   = project_axis(row, cy_q4, pt.z, inv_fy);
    return pt;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: point_%s expected %h, got %h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : watch
    point_t      got;
    point_t      want;
    logic [15:0] depth;
    if (rst) begin
      inv_factor = dpb_pkg::INV_FACTOR_RST;
      cx_q4      = dpb_pkg::CX_Q4_RST;
      cy_q4      = dpb_pkg::CY_Q4_RST;
      inv_fx     = dpb_pkg::INV_FX_RST;
      inv_fy     = dpb_pkg::INV_FY_RST;
      expected_points.delete();
    end else begin
      // Track register writes, masked to each register's width
      if (psel && penable && pwrite && pready) begin
        case (dpb_pkg::reg_idx_t'(paddr[dpb_pkg::ADDR_BITS-1:2]))
          dpb_pkg::REG_INV_FACTOR: inv_factor = pwdata;
          dpb_pkg::REG_CX_Q4:      cx_q4      = pwdata[14:0];
          dpb_pkg::REG_CY_Q4:      cy_q4      = pwdata[14:0];
          dpb_pkg::REG_INV_FX:     inv_fx     = pwdata[23:0];
          dpb_pkg::REG_INV_FY:     inv_fy     = pwdata[23:0];
          default: ;
        endcase
      end

      // Predict a point for each pixel transaction with a measured depth
      if (s_tvalid && s_tready) begin
        depth = s_tdata[15:0];
        if (depth != dpb_pkg::DEPTH_NONE_LO && depth != dpb_pkg::DEPTH_NONE_HI)
          expected_points.insert(expected_points.size(),
                                 backproject(depth, s_tdata[16 +: COORD_BITS],
                                             s_tdata[16 + COORD_BITS +: COORD_BITS]));
      end

      // Compare each point transaction with the oldest prediction
      if (m_tvalid && m_tready) begin
        got = m_tdata;
        if (expected_points.size() == 0) begin
          errors++;
          $display("%0t: point expected none, got %h", $time, m_tdata);
        end else begin
          want = expected_points.pop_front();
          check_field("x", want.x, got.x);
          check_field("y", want.y, got.y);
          check_field("z", want.z, got.z);
        end
      end
    end
    pending <= expected_points.size();
  end

endmodule

>>> verif/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam int COORD_W     = 11;
  localparam int SDATA_W     = ((16 + 2 * COORD_W + 7) / 8) * 8;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_WAIT  = 10;
  // Index past the end of the register map; writes there must be ignored
  localparam logic [2:0] UNUSED_IDX = 3'd5;

  logic                          clk;
  logic                          rst;
  logic [SDATA_W-1:0]            s_tdata;
  logic                          s_tvalid;
  logic                          s_tready;
  logic [95:0]                   m_tdata;
  logic                          m_tvalid;
  logic                          m_tready;
  logic                          psel;
  logic                          penable;
  logic                          pwrite;
  logic [dpb_pkg::ADDR_BITS-1:0] paddr;
  logic [31:0]                   pwdata;
  logic [31:0]                   prdata;
  logic                          pready;

  int errors;
  int pending;
  int src_idle_pct;
  int dst_idle_pct;
  bit hold_req;

  depth_pixel_backprojection #(.COORD_BITS(COORD_W)) dut (
    .clk(clk), .rst(rst),
    .s_tdata(s_tdata), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tdata(m_tdata), .m_tvalid(m_tvalid), .m_tready(m_tready),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  point_checker #(.COORD_BITS(COORD_W)) point_chk (
    .clk(clk), .rst(rst),
    .s_tdata(s_tdata), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tdata(m_tdata), .m_tvalid(m_tvalid), .m_tready(m_tready),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready),
    .errors(errors), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs
  initial begin
    #5_000_000;
    $display("depth_pixel_backprojection: mismatch");
    $finish;
  end

  // Point sink: random back-pressure, or one long hold-off on request
  initial begin : sink
    m_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= dst_idle_pct);
      end
    end
  end

  // Register write: setup cycle, then access cycle until pready
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= dpb_pkg::ADDR_BITS'(idx) << 2;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Offer one pixel after a random gap and hold it until the transaction completes
  task automatic send_pixel(input logic [15:0] depth, input logic [COORD_W-1:0] row,
                            input logic [COORD_W-1:0] col);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tdata  <= SDATA_W'({col, row, depth});
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
  endtask

  // Drop valid and wait until every predicted point has come out
  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic load_config(input logic [31:0] factor, input logic [31:0] cx,
                             input logic [31:0] cy, input logic [31:0] fx,
                             input logic [31:0] fy);
    write_reg(dpb_pkg::REG_INV_FACTOR, factor);
    write_reg(dpb_pkg::REG_CX_Q4, cx);
    write_reg(dpb_pkg::REG_CY_Q4, cy);
    write_reg(dpb_pkg::REG_INV_FX, fx);
    write_reg(dpb_pkg::REG_INV_FY, fy);
  endtask

  // Camera-like settings, or raw random words that also exercise width masking
  task automatic random_config(input bit realistic);
    if (realistic)
      load_config($urandom_range(32'h0100_0000, 32'h0000_1000), $urandom_range(32767),
                  $urandom_range(32767), $urandom_range(200000, 1000),
                  $urandom_range(200000, 1000));
    else
      load_config($urandom(), $urandom(), $urandom(), $urandom(), $urandom());
  endtask

  // Mostly measured depths, with missing-depth codes and depth extremes mixed in
  task automatic run_random(input int count);
    int          pick;
    logic [15:0] depth;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      if (pick < 5)
        depth = dpb_pkg::DEPTH_NONE_LO;
      else if (pick < 10)
        depth = dpb_pkg::DEPTH_NONE_HI;
      else if (pick < 12)
        depth = 16'd1;
      else if (pick < 14)
        depth = 16'd65534;
      else
        depth = 16'($urandom_range(65534, 1));
      send_pixel(depth, COORD_W'($urandom_range(2047)), COORD_W'($urandom_range(2047)));
    end
  endtask

  initial begin : stim
    rst          = 1'b1;
    s_tdata      = '0;
    s_tvalid     = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    hold_req     = 1'b0;
    src_idle_pct = 36;
    dst_idle_pct = 58;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings: depth extremes, missing depths, principal point, corners
    send_pixel(16'd1, 11'd0, 11'd0);
    send_pixel(16'd65534, 11'd2047, 11'd2047);
    send_pixel(dpb_pkg::DEPTH_NONE_LO, 11'd5, 11'd5);
    send_pixel(dpb_pkg::DEPTH_NONE_HI, 11'd7, 11'd7);
    send_pixel(16'd1000, 11'd240, 11'd320);
    send_pixel(16'd1000, 11'd0, 11'd0);
    send_pixel(16'hAAAA, 11'h555, 11'h2AA);
    send_pixel(16'h5555, 11'h2AA, 11'h555);
    send_pixel(16'd30000, 11'd2047, 11'd0);
    send_pixel(16'd30000, 11'd0, 11'd2047);
    settle();

    // Largest reciprocals: drive x to the positive and y to the negative saturation limit
    load_config(32'hFFFF_FFFF, 32'd0, 32'h7FFF, 32'hFF_FFFF, 32'hFF_FFFF);
    send_pixel(16'd65534, 11'd0, 11'd0);
    send_pixel(16'd65534, 11'd2047, 11'd2047);
    send_pixel(16'd65534, 11'd0, 11'd2047);
    send_pixel(16'd1, 11'd2047, 11'd0);
    settle();

    // Tiny depth scale: z truncates to zero but a point still comes out
    load_config(32'd1, 32'h7FFF, 32'd0, 32'd0, 32'd1);
    send_pixel(16'd12345, 11'd100, 11'd200);
    send_pixel(16'd65534, 11'd2047, 11'd0);
    settle();

    // Write past the register map, then confirm settings are unchanged
    write_reg(UNUSED_IDX, $urandom());
    send_pixel(16'd5000, 11'd10, 11'd10);
    settle();

    // Random phases across three idling regimes, long hold-off in the last
    for (int ph = 0; ph < 7; ph++) begin
      if (ph == 3) begin
        src_idle_pct = 58;
        dst_idle_pct = 36;
      end
      if (ph == 5) begin
        src_idle_pct = 0;
        dst_idle_pct = 0;
      end
      random_config(ph % 2 == 0);
      if (ph == 6)
        hold_req = 1'b1;
      run_random(200);
      settle();
    end

    if (errors == 0)
      $display("depth_pixel_backprojection: match");
    else
      $display("depth_pixel_backprojection: mismatch");
    $finish;
  end

endmodule
